@@ design/fcr_pkg.sv @@
package fcr_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int CHANNELS_DEF   = 2;
    localparam int MAX_DELAY_DEF  = 4096;

    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC      = 15;
    localparam int UNITY_GAIN     = 32768;
    localparam int DELAY_BITS     = 13;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // output queue depth; also the limit on items in flight
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DRY_GAIN     = 2'd0,
        REG_WET_GAIN     = 2'd1,
        REG_DELAY_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                          channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          out_channel;
    } out_item_t;

endpackage

@@ design/fcr_delay_ram.sv @@
module fcr_delay_ram #(
    parameter int DEPTH  = fcr_pkg::CHANNELS_DEF * fcr_pkg::MAX_DELAY_DEF,
    parameter int ADDR_W = $clog2(fcr_pkg::CHANNELS_DEF * fcr_pkg::MAX_DELAY_DEF)
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [ADDR_W-1:0]                      wr_addr,
    input  logic signed [fcr_pkg::SAMPLE_BITS-1:0] wr_data,
    input  logic                                   rd_en,
    input  logic [ADDR_W-1:0]                      rd_addr,
    output logic signed [fcr_pkg::SAMPLE_BITS-1:0] rd_data
);

    logic signed [fcr_pkg::SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [fcr_pkg::SAMPLE_BITS-1:0] rd_data_reg;

    // read during write to the same entry returns the old value
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/fcr_out_fifo.sv @@
module fcr_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fcr_pkg::out_item_t push_item,
    output logic               m_valid,
    input  logic               m_ready,
    output fcr_pkg::out_item_t m_data
);

    localparam int PTR_W = $clog2(fcr_pkg::OUT_DEPTH);

    fcr_pkg::out_item_t                slots_reg [fcr_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]                  wr_ptr_reg;
    logic [PTR_W-1:0]                  rd_ptr_reg;
    logic [fcr_pkg::OUT_CNT_W-1:0]     count_reg;
    logic                              pop;

    // no full check: the producer keeps items in flight at most the depth
    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + fcr_pkg::OUT_CNT_W'(1);
                2'b01:   count_reg <= count_reg - fcr_pkg::OUT_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ design/feedback_comb_reverb.sv @@
// Path from input accept to result valid: read, multiply, sum/saturate, then the result queue.
// Throughput: one item per cycle while fewer than OUT_DEPTH items are in flight; an item of
//   the same channel directly after another while the delay is one sample is held back,
//   since the item ahead, which writes its delayed value, is still in the multiply stage.
// Reset (aresetn, synchronous, active low): gains 0.5, delay 1, pointers zero; the
//   delay store reads as zero through per-channel fill marks, so there is no clearing pass.
module feedback_comb_reverb #(
    parameter int CHANNELS  = fcr_pkg::CHANNELS_DEF,
    parameter int MAX_DELAY = fcr_pkg::MAX_DELAY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  fcr_pkg::in_item_t                   s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output fcr_pkg::out_item_t                  m_data,

    input  logic                                cfg_wr_en,
    input  logic [fcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fcr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int SB     = fcr_pkg::SAMPLE_BITS;
    localparam int GB     = fcr_pkg::GAIN_BITS;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = $clog2(MAX_DELAY);
    localparam int DLY_W  = $clog2(MAX_DELAY + 1);
    localparam int DEPTH  = CHANNELS * MAX_DELAY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = SB + GB + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int CNT_W  = fcr_pkg::OUT_CNT_W;

    localparam longint SAT_MAX_L = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam longint SAT_MIN_L = -(64'sd1 <<< (SB - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(SAT_MAX_L);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(SAT_MIN_L);

    // configuration, stored already clamped
    logic [GB-1:0]                 dry_gain_reg;
    logic [GB-1:0]                 wet_gain_reg;
    logic [DLY_W-1:0]              delay_reg;
    logic [GB-1:0]                 cfg_gain;
    logic [GB-1:0]                 cfg_gain_clamped;
    logic [fcr_pkg::DELAY_BITS-1:0] cfg_delay;

    // per-channel pointer and fill mark (entries below the mark have been written)
    logic [POS_W-1:0]              pos_reg [CHANNELS];
    logic [DLY_W-1:0]              fill_reg [CHANNELS];

    logic [CNT_W-1:0]              inflight_reg;

    // accept side
    logic                          s_accept;
    logic                          m_accept;
    logic [CH_W-1:0]               ch_in;
    logic [POS_W-1:0]              pos_cur;
    logic [DLY_W-1:0]              pos_inc;
    logic [POS_W-1:0]              pos_new;
    logic [DLY_W-1:0]              fill_cur;
    logic                          entry_ok;
    logic [ADDR_W-1:0]             addr_in;
    logic                          hazard;

    // multiply stage
    logic                          s1_valid_reg;
    logic [CH_W-1:0]               s1_ch_reg;
    logic [POS_W-1:0]              s1_pos_reg;
    logic [ADDR_W-1:0]             s1_addr_reg;
    logic signed [SB-1:0]          s1_x_reg;
    logic                          s1_entry_ok_reg;
    logic signed [SB-1:0]          rd_data;
    logic signed [SB-1:0]          d_val;
    logic signed [PROD_W-1:0]      x_wide;
    logic signed [PROD_W-1:0]      d_wide;
    logic signed [PROD_W-1:0]      dry_wide;
    logic signed [PROD_W-1:0]      wet_wide;

    // sum / saturate stage
    logic                          s2_valid_reg;
    logic [CH_W-1:0]               s2_ch_reg;
    logic [ADDR_W-1:0]             s2_addr_reg;
    logic signed [PROD_W-1:0]      s2_dry_prod_reg;
    logic signed [PROD_W-1:0]      s2_wet_prod_reg;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_adj;
    logic signed [ACC_W-1:0]       quot;
    logic signed [SB-1:0]          y_val;

    // last written value, forwarded to the multiply stage
    logic                          fw_valid_reg;
    logic [ADDR_W-1:0]             fw_addr_reg;
    logic signed [SB-1:0]          fw_y_reg;

    fcr_pkg::out_item_t            push_item;

    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;

    // ---------------- configuration ----------------
    assign cfg_gain         = cfg_wdata[GB-1:0];
    assign cfg_gain_clamped = (32'(cfg_gain) > 32'(fcr_pkg::UNITY_GAIN))
                              ? GB'(fcr_pkg::UNITY_GAIN) : cfg_gain;
    assign cfg_delay        = cfg_wdata[fcr_pkg::DELAY_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_gain_reg <= GB'(16384);
            wet_gain_reg <= GB'(16384);
            delay_reg    <= DLY_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fcr_pkg::REG_DRY_GAIN: dry_gain_reg <= cfg_gain_clamped;
                fcr_pkg::REG_WET_GAIN: wet_gain_reg <= cfg_gain_clamped;
                fcr_pkg::REG_DELAY_LENGTH: begin
                    if (cfg_delay == '0) begin
                        delay_reg <= DLY_W'(1);
                    end else if (32'(cfg_delay) > 32'(MAX_DELAY)) begin
                        delay_reg <= DLY_W'(MAX_DELAY);
                    end else begin
                        delay_reg <= DLY_W'(cfg_delay);
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- accept / address ----------------
    assign ch_in    = (CHANNELS > 1) ? CH_W'(s_data.channel) : '0;
    assign pos_cur  = pos_reg[ch_in];
    assign fill_cur = fill_reg[ch_in];
    assign pos_inc  = DLY_W'(pos_cur) + DLY_W'(1);
    assign pos_new  = (pos_inc >= delay_reg) ? '0 : POS_W'(pos_inc);
    assign entry_ok = (DLY_W'(pos_cur) < fill_cur);
    assign addr_in  = ADDR_W'(32'(ch_in) * 32'(MAX_DELAY)) + ADDR_W'(pos_cur);

    // the entry being read is written by the item in the multiply stage: hold the input back
    assign hazard  = s1_valid_reg && (s1_ch_reg == ch_in) && (s1_pos_reg == pos_cur);
    assign s_ready = (inflight_reg < CNT_W'(fcr_pkg::OUT_DEPTH)) && !hazard;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
            inflight_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                pos_reg[ch_in] <= pos_new;
                if (pos_inc > fill_cur) begin
                    fill_reg[ch_in] <= pos_inc;
                end
            end
            case ({s_accept, m_accept})
                2'b10:   inflight_reg <= inflight_reg + CNT_W'(1);
                2'b01:   inflight_reg <= inflight_reg - CNT_W'(1);
                default: inflight_reg <= inflight_reg;
            endcase
            s1_valid_reg <= s_accept;
            s2_valid_reg <= s1_valid_reg;
            fw_valid_reg <= s2_valid_reg;
        end
    end

    // ---------------- delay store ----------------
    fcr_delay_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_fcr_delay_ram (
        .aclk    (aclk),
        .wr_en   (s2_valid_reg),
        .wr_addr (s2_addr_reg),
        .wr_data (y_val),
        .rd_en   (s_accept),
        .rd_addr (addr_in),
        .rd_data (rd_data)
    );

    // ---------------- multiply stage ----------------
    always_ff @(posedge aclk) begin
        s1_ch_reg       <= ch_in;
        s1_pos_reg      <= pos_cur;
        s1_addr_reg     <= addr_in;
        s1_x_reg        <= s_data.sample_in;
        s1_entry_ok_reg <= entry_ok;
    end

    always_comb begin
        if (fw_valid_reg && (fw_addr_reg == s1_addr_reg)) begin
            d_val = fw_y_reg;
        end else if (s1_entry_ok_reg) begin
            d_val = rd_data;
        end else begin
            d_val = '0;
        end
    end

    assign x_wide   = PROD_W'(s1_x_reg);
    assign d_wide   = PROD_W'(d_val);
    assign dry_wide = PROD_W'($signed({1'b0, dry_gain_reg}));
    assign wet_wide = PROD_W'($signed({1'b0, wet_gain_reg}));

    always_ff @(posedge aclk) begin
        s2_ch_reg       <= s1_ch_reg;
        s2_addr_reg     <= s1_addr_reg;
        s2_dry_prod_reg <= x_wide * dry_wide;
        s2_wet_prod_reg <= d_wide * wet_wide;
    end

    // ---------------- sum, truncate toward zero, saturate ----------------
    assign acc     = ACC_W'(s2_dry_prod_reg) + ACC_W'(s2_wet_prod_reg);
    assign acc_adj = acc[ACC_W-1] ? (acc + ACC_W'(fcr_pkg::UNITY_GAIN - 1)) : acc;
    assign quot    = acc_adj >>> fcr_pkg::GAIN_FRAC;

    always_comb begin
        if (quot > SAT_MAX) begin
            y_val = SAT_MAX[SB-1:0];
        end else if (quot < SAT_MIN) begin
            y_val = SAT_MIN[SB-1:0];
        end else begin
            y_val = quot[SB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        fw_addr_reg <= s2_addr_reg;
        fw_y_reg    <= y_val;
    end

    // ---------------- result queue ----------------
    assign push_item.sample_out  = y_val;
    assign push_item.out_channel = s2_ch_reg[0];

    fcr_out_fifo u_fcr_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s2_valid_reg),
        .push_item (push_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ design/fcr_checker.sv @@
module fcr_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               m_valid,
    input  logic               m_ready,
    input  fcr_pkg::out_item_t m_data
);

    localparam int OCNT_W = fcr_pkg::OUT_CNT_W + 1;

    logic [OCNT_W-1:0] outstanding_reg;
    logic              s_fire;
    logic              m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            case ({s_fire, m_fire})
                2'b10:   outstanding_reg <= outstanding_reg + OCNT_W'(1);
                2'b01:   outstanding_reg <= outstanding_reg - OCNT_W'(1);
                default: outstanding_reg <= outstanding_reg;
            endcase
        end
    end

    // no result without an item that caused it
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (outstanding_reg != '0))
        else $error("result shown with no item outstanding");

    // items in flight never exceed the result queue
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (outstanding_reg >= OCNT_W'(fcr_pkg::OUT_DEPTH)) |-> !s_ready)
        else $error("input ready with the result queue fully committed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result dropped or changed");

endmodule

bind feedback_comb_reverb fcr_checker u_fcr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ dv/comb_echo_checker.sv @@
module comb_echo_checker #(
    parameter int CHANNELS  = fcr_pkg::CHANNELS_DEF,
    parameter int MAX_DELAY = fcr_pkg::MAX_DELAY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    input  logic                              s_ready,
    input  fcr_pkg::in_item_t                 s_data,

    input  logic                              m_valid,
    input  logic                              m_ready,
    input  fcr_pkg::out_item_t                m_data,

    input  logic                              cfg_wr_en,
    input  logic [fcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fcr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,

    output int                                mismatches,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (fcr_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (fcr_pkg::SAMPLE_BITS - 1));

    logic signed [fcr_pkg::SAMPLE_BITS-1:0] echo_line [CHANNELS*MAX_DELAY];
    int unsigned                            tap [CHANNELS];
    logic [fcr_pkg::GAIN_BITS-1:0]          dry_q;
    logic [fcr_pkg::GAIN_BITS-1:0]          wet_q;
    logic [fcr_pkg::DELAY_BITS-1:0]         delay_q;

    fcr_pkg::out_item_t                     pending_mix [$];
    fcr_pkg::out_item_t                     want;
    int                                     fails = 0;

    assign mismatches = fails;

    // One feedback comb step: read the channel's tap, mix, write back, advance.
    function automatic fcr_pkg::out_item_t mix_sample(input fcr_pkg::in_item_t it);
        int unsigned        ch;
        int unsigned        slot;
        int unsigned        eff_delay;
        longint             x;
        longint             d;
        longint             dry;
        longint             wet;
        longint             acc;
        longint             y;
        fcr_pkg::out_item_t r;

        ch = it.channel % CHANNELS;
        if (delay_q == 0) eff_delay = 1;
        else if (delay_q > MAX_DELAY) eff_delay = MAX_DELAY;
        else eff_delay = delay_q;
        if (tap[ch] >= MAX_DELAY) tap[ch] = 0;

        slot = ch * MAX_DELAY + tap[ch];
        x    = it.sample_in;
        d    = echo_line[slot];
        dry  = (dry_q > fcr_pkg::UNITY_GAIN) ? fcr_pkg::UNITY_GAIN : dry_q;
        wet  = (wet_q > fcr_pkg::UNITY_GAIN) ? fcr_pkg::UNITY_GAIN : wet_q;

        // signed division truncates toward zero
        acc = x * dry + d * wet;
        y   = acc / fcr_pkg::UNITY_GAIN;
        if (y > SAMPLE_MAX) y = SAMPLE_MAX;
        if (y < SAMPLE_MIN) y = SAMPLE_MIN;

        echo_line[slot] = y[fcr_pkg::SAMPLE_BITS-1:0];
        tap[ch] = tap[ch] + 1;
        if (tap[ch] >= eff_delay) tap[ch] = 0;

        r.sample_out  = y[fcr_pkg::SAMPLE_BITS-1:0];
        r.out_channel = ch[0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (echo_line[i]) echo_line[i] = '0;
            foreach (tap[i]) tap[i] = 0;
            dry_q   = fcr_pkg::GAIN_BITS'(16384);
            wet_q   = fcr_pkg::GAIN_BITS'(16384);
            delay_q = fcr_pkg::DELAY_BITS'(1);
            pending_mix.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    fcr_pkg::REG_DRY_GAIN:     dry_q   = cfg_wdata;
                    fcr_pkg::REG_WET_GAIN:     wet_q   = cfg_wdata;
                    fcr_pkg::REG_DELAY_LENGTH: delay_q = cfg_wdata[fcr_pkg::DELAY_BITS-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (pending_mix.size() == 0) begin
                    $error("unexpected item: sample_out %0d, out_channel %0d",
                           m_data.sample_out, m_data.out_channel);
                    fails++;
                end else begin
                    want = pending_mix.pop_front();
                    if (m_data.sample_out !== want.sample_out) begin
                        $error("sample_out: expected %0d, got %0d",
                               want.sample_out, m_data.sample_out);
                        fails++;
                    end
                    if (m_data.out_channel !== want.out_channel) begin
                        $error("out_channel: expected %0d, got %0d",
                               want.out_channel, m_data.out_channel);
                        fails++;
                    end
                end
            end

            if (s_valid && s_ready) pending_mix.push_back(mix_sample(s_data));
        end
        outstanding <= pending_mix.size();
    end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = fcr_pkg::SAMPLE_BITS;
    localparam int GB = fcr_pkg::GAIN_BITS;
    localparam int DB = fcr_pkg::DELAY_BITS;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    fcr_pkg::in_item_t                  s_data    = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    fcr_pkg::out_item_t                 m_data;
    logic                               cfg_wr_en = 1'b0;
    logic [fcr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [fcr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    int                                 mismatches;
    int                                 outstanding;
    logic                               steady    = 1'b0;

    always #2 aclk = ~aclk;

    feedback_comb_reverb #(
        .CHANNELS  (fcr_pkg::CHANNELS_DEF),
        .MAX_DELAY (fcr_pkg::MAX_DELAY_DEF)
    ) dut (.*);

    comb_echo_checker #(
        .CHANNELS  (fcr_pkg::CHANNELS_DEF),
        .MAX_DELAY (fcr_pkg::MAX_DELAY_DEF)
    ) u_checker (.*);

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 37);
    end

    task automatic send_sample(input logic ch, input logic signed [SB-1:0] value);
        while (!steady && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data.channel   <= ch;
        s_data.sample_in <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every expected item has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_mix(input logic [GB-1:0] dry, input logic [GB-1:0] wet,
                           input logic [DB-1:0] dly);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= fcr_pkg::REG_DRY_GAIN;
        cfg_wdata <= dry;
        @(posedge aclk);
        cfg_index <= fcr_pkg::REG_WET_GAIN;
        cfg_wdata <= wet;
        @(posedge aclk);
        cfg_index <= fcr_pkg::REG_DELAY_LENGTH;
        cfg_wdata <= fcr_pkg::CFG_DATA_BITS'(dly);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [GB-1:0] random_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return GB'(fcr_pkg::UNITY_GAIN);
            2:       return GB'($urandom_range(65535, fcr_pkg::UNITY_GAIN + 1));
            default: return GB'($urandom_range(fcr_pkg::UNITY_GAIN));
        endcase
    endfunction

    function automatic logic [DB-1:0] random_delay();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DB'(fcr_pkg::MAX_DELAY_DEF);
            2:       return DB'($urandom_range(8191, fcr_pkg::MAX_DELAY_DEF + 1));
            3:       return DB'(1);
            default: return DB'($urandom_range(64, 2));
        endcase
    endfunction

    function automatic logic signed [SB-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0) return S_MAX;
        if (pick == 1) return S_MIN;
        if (pick < 6) return SB'(int'($urandom_range(2000)) - 1000);
        return SB'($urandom());
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!aresetn);

        // reset gains 0.5/0.5, delay 1; consecutive samples on the same channel
        send_sample(1'b0, S_MAX);
        send_sample(1'b0, S_MAX);
        send_sample(1'b1, S_MIN);
        send_sample(1'b1, '0);
        send_sample(1'b1, SB'(-1));
        send_sample(1'b0, SB'(1));

        // unity gains: feedback drives into saturation
        set_mix(GB'(fcr_pkg::UNITY_GAIN), GB'(fcr_pkg::UNITY_GAIN), DB'(3));
        repeat (4) send_sample(1'b0, S_MAX);
        repeat (4) send_sample(1'b1, S_MIN);

        // gains above unity clamp, delay zero acts as one
        set_mix('1, '1, '0);
        send_sample(1'b0, S_MAX);
        send_sample(1'b0, S_MIN);
        send_sample(1'b1, S_MAX);
        send_sample(1'b1, S_MIN);

        // dry muted, delay beyond the store depth
        set_mix('0, GB'(fcr_pkg::UNITY_GAIN), '1);
        send_sample(1'b0, SB'(12345));
        send_sample(1'b0, SB'(-5));
        send_sample(1'b1, SB'(77));

        // shrink delay so that the channel 0 pointer lies past its end
        set_mix(GB'(20000), GB'(30000), DB'(2));
        send_sample(1'b0, SB'(100));
        send_sample(1'b0, SB'(-100));
        send_sample(1'b0, SB'(4000));

        for (int phase = 0; phase < 14; phase++) begin
            set_mix(random_gain(), random_gain(), random_delay());
            steady <= (phase == 7);
            repeat (100) send_sample(1'($urandom_range(1)), random_sample());
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
